>>> hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

  localparam logic [31:0] MPC_RST  = 32'd1580945;
  localparam logic [31:0] HG_RST   = 32'd432608;
  localparam logic [10:0] RATE_RST = 11'd1;

  localparam logic [1:0] REG_MPC  = 2'd0;
  localparam logic [1:0] REG_HG   = 2'd1;
  localparam logic [1:0] REG_RATE = 2'd2;

  localparam int ATAN_AW = 5;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,
    32'd40,        32'd20,        32'd10,        32'd5,
    32'd2,         32'd1,         32'd0,         32'd0
  };

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DC   = 4'd1;
  localparam logic [3:0] ST_T    = 4'd2;
  localparam logic [3:0] ST_TH   = 4'd3;
  localparam logic [3:0] ST_WAIT = 4'd4;
  localparam logic [3:0] ST_CX0  = 4'd5;
  localparam logic [3:0] ST_CX1  = 4'd6;
  localparam logic [3:0] ST_CY0  = 4'd7;
  localparam logic [3:0] ST_CY1  = 4'd8;
  localparam logic [3:0] ST_VX   = 4'd9;
  localparam logic [3:0] ST_VY   = 4'd10;
  localparam logic [3:0] ST_VH   = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  typedef struct packed {
    logic [31:0] meters_per_count;
    logic [31:0] heading_gain;
    logic [10:0] update_rate;
  } cfg_t;

  typedef struct packed {
    logic [3:0] step;
    logic       load_in;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic        cos_neg;
    logic [31:0] cos_mag;
    logic        sin_neg;
    logic [31:0] sin_mag;
  } trig_t;

endpackage

>>> hw/rtl/ddo_cordic.sv
`timescale 1ns / 1ps

module ddo_cordic #(
  parameter int ANGLE_STEPS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          angle,
  output logic                 done,
  output ddo_pkg::trig_t       trig
);

  localparam int IW = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int AW = ddo_pkg::ATAN_AW;
  localparam logic [IW-1:0] LAST = IW'(ANGLE_STEPS - 1);

  logic                busy;
  logic                flip;
  logic [IW-1:0]       iter;
  logic signed [32:0]  x;
  logic signed [32:0]  y;
  logic signed [32:0]  z;
  logic [AW-1:0]       idx;
  logic signed [32:0]  xs;
  logic signed [32:0]  ys;
  logic signed [32:0]  za;
  logic [31:0]         ang_rot;
  logic                flip_in;
  logic [31:0]         ang_fold;
  logic signed [32:0]  fx;
  logic signed [32:0]  fy;
  logic signed [32:0]  nfx;
  logic signed [32:0]  nfy;

  always_comb begin
    ang_rot  = angle + 32'h4000_0000;
    flip_in  = ang_rot[31];
    ang_fold = flip_in ? angle - 32'h8000_0000 : angle;
    idx      = AW'(iter);
    xs       = x >>> iter;
    ys       = y >>> iter;
    za       = $signed({1'b0, ddo_pkg::ATAN_TAB[idx]});
    fx       = flip ? -x : x;
    fy       = flip ? -y : y;
    nfx      = -fx;
    nfy      = -fy;
    trig.cos_neg = fx[32];
    trig.cos_mag = fx[32] ? nfx[31:0] : fx[31:0];
    trig.sin_neg = fy[32];
    trig.sin_mag = fy[32] ? nfy[31:0] : fy[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && iter == LAST) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= ddo_pkg::CORDIC_X0;
      y    <= '0;
      z    <= $signed({ang_fold[31], ang_fold});
      iter <= '0;
      flip <= flip_in;
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - za;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + za;
      end
      iter <= iter + 1'b1;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("cordic not busy after start");

  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(busy && done))
    else $error("cordic busy and done together");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && iter == LAST) |=> done)
    else $error("cordic missed done after last iteration");

endmodule

>>> hw/rtl/ddo_ctrl.sv
`timescale 1ns / 1ps

module ddo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  logic           cordic_done,
  output logic           cordic_start,
  output ddo_pkg::cmd_t  cmd
);

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       finish;
  logic       m_tvalid_next;

  assign s_tready     = (state == ddo_pkg::ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign finish       = (state == ddo_pkg::ST_FIN) && (!m_tvalid || m_tready);
  assign cordic_start = accept;

  assign cmd.step    = state;
  assign cmd.load_in = accept;
  assign cmd.finish  = finish;

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::ST_IDLE: if (accept) state_next = ddo_pkg::ST_DC;
      ddo_pkg::ST_DC:   state_next = ddo_pkg::ST_T;
      ddo_pkg::ST_T:    state_next = ddo_pkg::ST_TH;
      ddo_pkg::ST_TH:   state_next = ddo_pkg::ST_WAIT;
      ddo_pkg::ST_WAIT: if (cordic_done) state_next = ddo_pkg::ST_CX0;
      ddo_pkg::ST_CX0:  state_next = ddo_pkg::ST_CX1;
      ddo_pkg::ST_CX1:  state_next = ddo_pkg::ST_CY0;
      ddo_pkg::ST_CY0:  state_next = ddo_pkg::ST_CY1;
      ddo_pkg::ST_CY1:  state_next = ddo_pkg::ST_VX;
      ddo_pkg::ST_VX:   state_next = ddo_pkg::ST_VY;
      ddo_pkg::ST_VY:   state_next = ddo_pkg::ST_VH;
      ddo_pkg::ST_VH:   state_next = ddo_pkg::ST_FIN;
      ddo_pkg::ST_FIN:  if (finish) state_next = ddo_pkg::ST_IDLE;
      default:          state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (finish) m_tvalid_next = 1'b1;
    else if (m_tready)   m_tvalid_next = 1'b0;
    else                 m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ddo_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ddo_pkg::ST_DC)
    else $error("accepted beat did not start the sequence");

  a_trig_ready: assert property (@(posedge clk) disable iff (rst)
    state == ddo_pkg::ST_CX0 |-> cordic_done)
    else $error("projection started before cordic finished");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> m_tvalid)
    else $error("result not presented after finish");

endmodule

>>> hw/rtl/ddo_datapath.sv
`timescale 1ns / 1ps

module ddo_datapath (
  input  logic            clk,
  input  logic            rst,
  input  ddo_pkg::cfg_t   cfg,
  input  ddo_pkg::cmd_t   cmd,
  input  logic [63:0]     s_tdata,
  input  ddo_pkg::trig_t  trig,
  output logic [31:0]     heading,
  output logic [191:0]    m_tdata
);

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  function automatic logic [31:0] vel_sat(input logic neg, input logic big,
                                          input logic rate_zero, input logic [42:0] p);
    logic [31:0] r;
    if (rate_zero)  r = '0;
    else if (big)   r = neg ? SAT_MIN : SAT_MAX;
    else if (!neg)  r = (|p[42:31]) ? SAT_MAX : p[31:0];
    else            r = (p > 43'h0_8000_0000) ? SAT_MIN : (32'd0 - p[31:0]);
    return r;
  endfunction

  function automatic logic [31:0] pos_add(input logic [31:0] acc, input logic neg,
                                          input logic [47:0] mag);
    logic [49:0] a;
    logic [49:0] d;
    logic [49:0] s;
    logic [31:0] r;
    a = {{18{acc[31]}}, acc};
    d = {2'b00, mag};
    if (neg) d = 50'd0 - d;
    s = a + d;
    if (!s[49] && (|s[48:31]))      r = SAT_MAX;
    else if (s[49] && !(&s[48:31])) r = SAT_MIN;
    else                            r = s[31:0];
    return r;
  endfunction

  logic [31:0] left_count;
  logic [31:0] right_count;
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  logic [31:0] acc_heading;

  logic        sum_neg;
  logic [32:0] msum;
  logic        diff_neg;
  logic [31:0] mdiff;
  logic [63:0] prod;
  logic [46:0] dcm;
  logic [31:0] t_lo;
  logic        t_big;
  logic [55:0] p_lo;
  logic [47:0] dxm;
  logic [47:0] dym;
  logic [31:0] vx_t;
  logic [31:0] vy_t;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_heading;

  logic [31:0] dl;
  logic [31:0] dr;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [32:0] nsum;
  logic [32:0] ndiff;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] dc_wide;
  logic [77:0] mag_full;
  logic        rate_zero;
  logic        dx_neg;
  logic        dy_neg;

  assign left_count  = s_tdata[31:0];
  assign right_count = s_tdata[63:32];

  always_comb begin
    dl        = left_count - prev_left;
    dr        = right_count - prev_right;
    sum       = {dl[31], dl} + {dr[31], dr};
    diff      = {dr[31], dr} - {dl[31], dl};
    nsum      = 33'd0 - sum;
    ndiff     = 33'd0 - diff;
    dc_wide   = prod + (msum[32] ? {cfg.meters_per_count, 32'd0} : 64'd0);
    mag_full  = {prod[53:0], 24'd0} + {22'd0, p_lo};
    rate_zero = (cfg.update_rate == '0);
    dx_neg    = sum_neg ^ trig.cos_neg;
    dy_neg    = sum_neg ^ trig.sin_neg;
  end

  always_comb begin
    unique case (cmd.step)
      ddo_pkg::ST_DC: begin
        mul_a = msum[31:0];
        mul_b = cfg.meters_per_count;
      end
      ddo_pkg::ST_T: begin
        mul_a = mdiff;
        mul_b = cfg.heading_gain;
      end
      ddo_pkg::ST_CX0: begin
        mul_a = {8'd0, dcm[23:0]};
        mul_b = trig.cos_mag;
      end
      ddo_pkg::ST_CX1: begin
        mul_a = {9'd0, dcm[46:24]};
        mul_b = trig.cos_mag;
      end
      ddo_pkg::ST_CY0: begin
        mul_a = {8'd0, dcm[23:0]};
        mul_b = trig.sin_mag;
      end
      ddo_pkg::ST_CY1: begin
        mul_a = {9'd0, dcm[46:24]};
        mul_b = trig.sin_mag;
      end
      ddo_pkg::ST_VX: begin
        mul_a = dxm[31:0];
        mul_b = {21'd0, cfg.update_rate};
      end
      ddo_pkg::ST_VY: begin
        mul_a = dym[31:0];
        mul_b = {21'd0, cfg.update_rate};
      end
      ddo_pkg::ST_VH, ddo_pkg::ST_FIN: begin
        mul_a = t_lo;
        mul_b = {21'd0, cfg.update_rate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (cmd.load_in) begin
      sum_neg  <= sum[32];
      msum     <= sum[32] ? nsum : sum;
      diff_neg <= diff[32];
      mdiff    <= diff[32] ? ndiff[31:0] : diff[31:0];
    end
    unique case (cmd.step)
      ddo_pkg::ST_T:   dcm <= dc_wide[63:17];
      ddo_pkg::ST_TH: begin
        t_lo  <= prod[31:0];
        t_big <= |prod[63:32];
      end
      ddo_pkg::ST_CX1, ddo_pkg::ST_CY1: p_lo <= prod[55:0];
      ddo_pkg::ST_CY0: dxm <= mag_full[77:30];
      ddo_pkg::ST_VX:  dym <= mag_full[77:30];
      ddo_pkg::ST_VY:  vx_t <= vel_sat(dx_neg, |dxm[47:32], rate_zero, prod[42:0]);
      ddo_pkg::ST_VH:  vy_t <= vel_sat(dy_neg, |dym[47:32], rate_zero, prod[42:0]);
      default: ;
    endcase
    if (cmd.finish) begin
      vel_x       <= vx_t;
      vel_y       <= vy_t;
      vel_heading <= vel_sat(diff_neg, t_big, rate_zero, prod[42:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= '0;
      prev_right  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      if (cmd.load_in) begin
        prev_left  <= left_count;
        prev_right <= right_count;
      end
      if (cmd.finish) begin
        acc_x       <= pos_add(acc_x, dx_neg, dxm);
        acc_y       <= pos_add(acc_y, dy_neg, dym);
        acc_heading <= acc_heading + (diff_neg ? 32'd0 - t_lo : t_lo);
      end
    end
  end

  assign heading = acc_heading;
  assign m_tdata = {vel_heading, vel_y, vel_x, acc_heading, acc_y, acc_x};

endmodule

>>> hw/rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_*       in   64     tdata: left_count, right_count
// m_*       out  192    tdata: pos_x, pos_y, heading, vel_x, vel_y, vel_heading
// cfg_*     in   32     write index 0..2: meters_per_count, heading_gain, update_rate
//
// One tick runs from accept to result through the iterative CORDIC loop plus
// the seven passes through one shared 32x32 multiplier that need its result;
// the two passes before them overlap the loop.
// s_tready is high only between ticks; the next tick may be accepted while the
// previous result still waits on m_tready, and holds before its pose update.
// rst is synchronous: pose, previous counts and registers return to defaults.

module differential_drive_odometry #(
  parameter int ANGLE_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // left_count, right_count
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // pos_x, pos_y, heading, vel_x, vel_y, vel_heading
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  ddo_pkg::cfg_t  cfg;
  ddo_pkg::cmd_t  cmd;
  ddo_pkg::trig_t trig;
  logic           cordic_start;
  logic           cordic_done;
  logic [31:0]    heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.meters_per_count <= ddo_pkg::MPC_RST;
      cfg.heading_gain     <= ddo_pkg::HG_RST;
      cfg.update_rate      <= ddo_pkg::RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ddo_pkg::REG_MPC:  cfg.meters_per_count <= cfg_wdata;
        ddo_pkg::REG_HG:   cfg.heading_gain     <= cfg_wdata;
        ddo_pkg::REG_RATE: cfg.update_rate      <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  ddo_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cordic_done  (cordic_done),
    .cordic_start (cordic_start),
    .cmd          (cmd)
  );

  ddo_cordic #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (heading),
    .done  (cordic_done),
    .trig  (trig)
  );

  ddo_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .trig    (trig),
    .heading (heading),
    .m_tdata (m_tdata)
  );

endmodule

>>> bench/odometry_checker.sv
`timescale 1ns / 1ps

module odometry_checker #(
  parameter int ANGLE_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,    // left_count, right_count
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,    // pos_x, pos_y, heading, vel_x, vel_y, vel_heading
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           pending,
  output int           failures,
  output int           checked
);

  typedef struct packed {
    logic [31:0] vel_heading;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;
  localparam longint GAIN_X0 = 64'sd652032874;
  localparam longint TURN_CAP = 64'sd4294967296;

  localparam logic [31:0] ARC_STEP [32] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,
    32'd40,        32'd20,        32'd10,        32'd5,
    32'd2,         32'd1,         32'd0,         32'd0
  };

  logic [31:0] travel_scale;
  logic [31:0] turn_gain;
  logic [10:0] tick_rate;
  logic [31:0] last_left, last_right;
  logic [31:0] x_acc, y_acc, theta_acc;

  pose_t pose_queue [$];
  pose_t want, got;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > SAT_HI) return 32'h7FFF_FFFF;
    if (v < SAT_LO) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // (a * c) >> 30 with the magnitude truncated toward zero
  function automatic longint scale_q30(input longint a, input longint c);
    logic [63:0] ma, mc;
    logic [95:0] prod;
    longint r;
    ma = (a < 0) ? -a : a;
    mc = (c < 0) ? -c : c;
    prod = ma * mc;
    r = prod[93:30];
    return ((a < 0) != (c < 0)) ? -r : r;
  endfunction

  // rotation-mode CORDIC, angle folded into the right half plane first
  function automatic void heading_trig(input logic [31:0] ang,
                                       output longint c, output longint s);
    logic [31:0] a;
    logic flip;
    longint z, x, y, nx;
    int i;
    a = ang + 32'h4000_0000;
    flip = a[31];
    a = flip ? ang - 32'h8000_0000 : ang;
    z = longint'($signed(a));
    x = GAIN_X0;
    y = 0;
    for (i = 0; i < ANGLE_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ARC_STEP[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ARC_STEP[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t predict_pose(input logic [31:0] l, input logic [31:0] r);
    logic [31:0] wl, wr, turn_lo;
    logic [63:0] msum, mdiff, dcm, turn;
    longint dl, dr, sum, diff, dc, cs, sn, dx, dy, vth, rate;
    pose_t p;
    wl = l - last_left;
    wr = r - last_right;
    dl = longint'($signed(wl));
    dr = longint'($signed(wr));
    sum = dl + dr;
    diff = dr - dl;
    msum = (sum < 0) ? -sum : sum;
    mdiff = (diff < 0) ? -diff : diff;
    dcm = (msum * travel_scale) >> 17;
    dc = (sum < 0) ? -longint'(dcm) : longint'(dcm);
    turn = mdiff * turn_gain;
    turn_lo = turn[31:0];
    rate = tick_rate;

    last_left = l;
    last_right = r;
    heading_trig(theta_acc, cs, sn);
    dx = scale_q30(dc, cs);
    dy = scale_q30(dc, sn);
    x_acc = clamp32(longint'($signed(x_acc)) + dx);
    y_acc = clamp32(longint'($signed(y_acc)) + dy);
    theta_acc = theta_acc + ((diff < 0) ? (32'd0 - turn_lo) : turn_lo);

    if (turn > 64'h8000_0000) vth = (diff < 0) ? -TURN_CAP : TURN_CAP;
    else vth = (diff < 0) ? -longint'(turn) : longint'(turn);
    if (!(rate != 0 && (vth > SAT_HI || vth < SAT_LO))) vth = vth * rate;

    p.pos_x = x_acc;
    p.pos_y = y_acc;
    p.heading = theta_acc;
    p.vel_x = clamp32(dx * rate);
    p.vel_y = clamp32(dy * rate);
    p.vel_heading = clamp32(vth);
    return p;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d got %0d", field, $signed(exp_v), $signed(act_v));
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      travel_scale = 32'd1580945;
      turn_gain = 32'd432608;
      tick_rate = 11'd1;
      last_left = '0;
      last_right = '0;
      x_acc = '0;
      y_acc = '0;
      theta_acc = '0;
      pose_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ddo_pkg::REG_MPC:  travel_scale = cfg_wdata;
          ddo_pkg::REG_HG:   turn_gain = cfg_wdata;
          ddo_pkg::REG_RATE: tick_rate = cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pose_queue.push_back(predict_pose(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        if (pose_queue.size() == 0) begin
          $error("pose beat with no tick outstanding");
          failures++;
        end else begin
          want = pose_queue.pop_front();
          got = m_tdata;
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("heading", want.heading, got.heading);
          check_field("vel_x", want.vel_x, got.vel_x);
          check_field("vel_y", want.vel_y, got.vel_y);
          check_field("vel_heading", want.vel_heading, got.vel_heading);
          checked++;
        end
      end
    end
    pending = pose_queue.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ANGLE_STEPS = 24;
  localparam int LATENCY = ANGLE_STEPS + 10;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int TICKS_PER_PHASE = 240;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;    // left_count, right_count
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;    // pos_x, pos_y, heading, vel_x, vel_y, vel_heading
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  int pending, failures, checked;
  int setting_count;
  logic [31:0] cur_left, cur_right;
  logic hold_req, hold_done, quiet, tx_gaps;

  differential_drive_odometry #(.ANGLE_STEPS(ANGLE_STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  odometry_checker #(.ANGLE_STEPS(ANGLE_STEPS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .pending(pending), .failures(failures), .checked(checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin : watchdog
    #(12 * 600000);
    $display("FAIL differential_drive_odometry");
    $finish;
  end

  initial begin : receiver
    int len;
    logic level;
    m_tready = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        level = 1'b0;
        len = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (quiet) begin
        level = 1'b1;
        len = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        len = $urandom_range(1, 7);
      end else begin
        level = 1'b1;
        len = $urandom_range(1, 12);
      end
      m_tready <= level;
      repeat (len) @(negedge clk);
    end
  end

  task automatic send_tick(input logic [31:0] l, input logic [31:0] r);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    cur_left = l;
    cur_right = r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_step(input int dl, input int dr);
    send_tick(cur_left + dl, cur_right + dr);
  endtask

  task automatic send_random_tick();
    int kind;
    logic [31:0] span, l, r;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      span = (kind < 70) ? (32'd1 << $urandom_range(0, 12)) : (32'd1 << $urandom_range(13, 30));
      l = cur_left + $urandom_range(0, 2 * span) - span;
      r = cur_right + $urandom_range(0, 2 * span) - span;
    end else if (kind < 90) begin
      l = $urandom;
      r = $urandom;
    end else if (kind < 95) begin
      l = cur_left;
      r = cur_right;
    end else begin
      l = 32'h8000_0000 + $urandom_range(0, 32) - 16;
      r = 32'h8000_0000 + $urandom_range(0, 32) - 16;
    end
    send_tick(l, r);
  endtask

  // drop valid, drain every pose, then let the pipeline go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] mpc, hg, rate_word);
    cfg_we <= 1'b1;
    cfg_addr <= ddo_pkg::REG_MPC;
    cfg_wdata <= mpc;
    @(negedge clk);
    cfg_addr <= ddo_pkg::REG_HG;
    cfg_wdata <= hg;
    @(negedge clk);
    cfg_addr <= ddo_pkg::REG_RATE;
    cfg_wdata <= rate_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin : stimulus
    logic [31:0] mpc, hg, rate_word;
    int p, n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = ddo_pkg::REG_MPC;
    cfg_wdata = '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    tx_gaps = 1'b1;
    cur_left = '0;
    cur_right = '0;
    setting_count = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first tick sees the full counts; then standstill, wrap and field extremes
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(32'd1000, 32'd1000);
    send_tick(32'd1000, 32'd5000);
    send_tick(-32'sd3000, 32'd8000);
    send_tick(32'h7FFF_FFF0, 32'h7FFF_FFF0);
    send_tick(32'h8000_0010, 32'h8000_0010);
    settle();

    configure(32'd0, 32'd0, 32'd0);
    send_tick(cur_left + 32'd100, cur_right + 32'd200);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    settle();

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_07FF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'h7FFF_FFFE, 32'h8000_0001);
    settle();

    // quarter turn per tick walks the heading across the fold points;
    // upper write bits above the rate field are ignored
    configure(32'h1000_0000, 32'h4000_0000, 32'hABCD_F400);
    repeat (4) send_step(1, 2);
    settle();

    // turn product of exactly half a revolution, both signs
    configure(32'h0001_0000, 32'h8000_0000, 32'd3);
    send_step(0, 1);
    send_step(1, 0);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      mpc = (p == 3) ? $urandom : $urandom_range(32'h0001_0000, 32'h0100_0000);
      hg = (p % 2 == 1) ? $urandom : $urandom_range(0, 32'h0040_0000);
      case (p)
        0: rate_word = 32'd1;
        1: rate_word = 32'd1024;
        4: rate_word = 32'd2047;
        default: rate_word = $urandom_range(0, 2047);
      endcase
      configure(mpc, hg, rate_word);
      if (p == 1) hold_req = 1'b1;
      if (p == RANDOM_PHASES - 1) begin
        quiet = 1'b1;
        tx_gaps = 1'b0;
      end
      for (n = 0; n < TICKS_PER_PHASE; n++) send_random_tick();
      settle();
    end

    $display("Checked %0d odometry ticks across %0d register settings,",
             checked, setting_count);
    $display("with random gaps on both channels and one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("PASS differential_drive_odometry");
    end else begin
      $display("FAIL differential_drive_odometry");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_cordic.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/ddo_datapath.sv
hw/rtl/differential_drive_odometry.sv
bench/odometry_checker.sv
bench/testbench.sv
